[rtl/gfau_pkg.sv]
// ----------------------------------------------------------------------------
// gfau_pkg
// Types, command codes and GF(2^12) helper functions for the arithmetic unit.
// ----------------------------------------------------------------------------
package gfau_pkg;

	localparam int FIELD_BITS = 12;
	localparam int PROD_BITS  = 2 * FIELD_BITS - 1;
	localparam int HIGH_BITS  = PROD_BITS - FIELD_BITS;
	// The reduction polynomial is x^12 + x^3 + 1, so x^12 folds onto x^3 + 1.
	localparam int POLY_TAP   = 3;
	localparam int FOLD_BITS  = FIELD_BITS + 2;

	typedef logic [FIELD_BITS-1:0] elem_t;
	typedef logic [PROD_BITS-1:0]  prod_t;

	typedef enum logic [1:0] {
		CMD_MUL = 2'd0,
		CMD_SQR = 2'd1,
		CMD_INV = 2'd2,
		CMD_NEQ = 2'd3
	} cmd_t;

	// One beat as it travels down the pipeline.
	typedef struct packed {
		logic  valid;
		cmd_t  cmd;
		elem_t a;
		elem_t p3;
		elem_t acc;
	} pipe_t;

	// Reduces a carry-less product in two folds of the high part.
	function automatic elem_t gf_reduce(prod_t p);
		logic [FOLD_BITS-1:0] hi;
		logic [FOLD_BITS-1:0] t;
		logic [1:0]           h2;
		hi = {3'b000, p[PROD_BITS-1:FIELD_BITS]};
		t  = hi ^ (hi << POLY_TAP) ^ {2'b00, p[FIELD_BITS-1:0]};
		h2 = t[FOLD_BITS-1:FIELD_BITS];
		return t[FIELD_BITS-1:0] ^ {10'b0, h2} ^ {7'b0, h2, 3'b000};
	endfunction

	function automatic elem_t gf_mul(elem_t x, elem_t y);
		prod_t p;
		p = '0;
		for (int i = 0; i < FIELD_BITS; i++) begin
			if (y[i]) begin
				p = p ^ ({{HIGH_BITS{1'b0}}, x} << i);
			end
		end
		return gf_reduce(p);
	endfunction

	// Squaring only spreads the bits apart, so it is a shallow linear map.
	function automatic elem_t gf_sqr(elem_t x);
		prod_t p;
		p = '0;
		for (int i = 0; i < FIELD_BITS; i++) begin
			p[2*i] = x[i];
		end
		return gf_reduce(p);
	endfunction

	// Repeated squaring by a constant count, still one fixed linear map.
	function automatic elem_t gf_sqr_n(elem_t x, int n);
		elem_t r;
		r = x;
		for (int i = 0; i < n; i++) begin
			r = gf_sqr(r);
		end
		return r;
	endfunction

endpackage

[rtl/gfau_front.sv]
// ----------------------------------------------------------------------------
// gfau_front
// First stage: command decode, the shared multiplier and the inequality mask.
// ----------------------------------------------------------------------------
module gfau_front import gfau_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic [1:0] in_cmd,
	input  elem_t      in_a,
	input  elem_t      in_b,
	output pipe_t      out_s1
);

	cmd_t  cmd;
	elem_t mul_x;
	elem_t mul_y;
	elem_t prod;
	elem_t acc;

	always_comb begin
		cmd   = cmd_t'(in_cmd);
		// Inversion starts with a^2 * a; squaring uses a * a.
		mul_x = (cmd == CMD_INV) ? gf_sqr(in_a) : in_a;
		mul_y = (cmd == CMD_MUL) ? in_b : in_a;
		prod  = gf_mul(mul_x, mul_y);
		if (cmd == CMD_NEQ) begin
			acc = (in_a != in_b) ? '1 : '0;
		end else begin
			acc = prod;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_s1 <= '0;
		end else begin
			out_s1.valid <= in_valid;
			out_s1.cmd   <= cmd;
			out_s1.a     <= in_a;
			out_s1.p3    <= prod;
			out_s1.acc   <= acc;
		end
	end

endmodule

[rtl/gfau_mul_stage.sv]
// ----------------------------------------------------------------------------
// gfau_mul_stage
// One step of the inversion chain: a field multiply and a pipeline register.
// ----------------------------------------------------------------------------
module gfau_mul_stage import gfau_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  pipe_t in_s,
	input  elem_t mul_x,
	input  elem_t mul_y,
	output pipe_t out_s
);

	elem_t prod;

	// Only an inversion moves on through the chain; other results pass along.
	always_comb begin
		prod = (in_s.cmd == CMD_INV) ? gf_mul(mul_x, mul_y) : in_s.acc;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_s <= '0;
		end else begin
			out_s.valid <= in_s.valid;
			out_s.cmd   <= in_s.cmd;
			out_s.a     <= in_s.a;
			out_s.p3    <= in_s.p3;
			out_s.acc   <= prod;
		end
	end

endmodule

[rtl/gfau_out.sv]
// ----------------------------------------------------------------------------
// gfau_out
// Output register: final squaring of the inversion chain and the strobe.
// ----------------------------------------------------------------------------
module gfau_out import gfau_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  pipe_t in_s,
	output logic  done,
	output elem_t result
);

	elem_t res_d;

	always_comb begin
		res_d = (in_s.cmd == CMD_INV) ? gf_sqr(in_s.acc) : in_s.acc;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= in_s.valid;
		end
	end

	always_ff @(posedge clk) begin
		result <= res_d;
	end

endmodule

[rtl/gf4096_arithmetic_unit_core.sv]
// ----------------------------------------------------------------------------
// gf4096_arithmetic_unit_core
// Pipelined GF(2^12) unit: multiply, square, invert and inequality mask.
// ----------------------------------------------------------------------------
//
// Channel   Ports                              Handshake
// command   start, cmd, operand_a, operand_b   taken when start is high and busy low
// result    done, result                       one-cycle strobe, cannot be held off
//
// Every beat passes six register stages: the command is taken into the
// first, the result appears with done out of the last, and a new command may
// be issued on every cycle. The length is set by the inversion, which is a
// fixed chain of five field multiplies and one final squaring, one multiply
// per stage. Busy is always low, since nothing downstream can stall the
// pipe. Reset clears the pipeline stages and the done strobe; only the
// result register is left alone.
//
module gf4096_arithmetic_unit_core import gfau_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  cmd,
	input  logic [11:0] operand_a,
	input  logic [11:0] operand_b,
	output logic        done,
	output logic [11:0] result
);

	pipe_t pipe_s1;
	pipe_t pipe_s2;
	pipe_t pipe_s3;
	pipe_t pipe_s4;
	pipe_t pipe_s5;

	// The pipeline never stalls, so a command is always welcome.
	assign busy = 1'b0;

	// Stage one: the multiply or square itself, the mask, or a^3 for inversion.
	gfau_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(start),
		.in_cmd  (cmd),
		.in_a    (operand_a),
		.in_b    (operand_b),
		.out_s1  (pipe_s1)
	);

	// Stage two: a^15 = (a^3)^4 * a^3.
	gfau_mul_stage u_stage2 (
		.clk   (clk),
		.arst_n(arst_n),
		.in_s  (pipe_s1),
		.mul_x (gf_sqr_n(pipe_s1.acc, 2)),
		.mul_y (pipe_s1.acc),
		.out_s (pipe_s2)
	);

	// Stage three: a^255 = (a^15)^16 * a^15.
	gfau_mul_stage u_stage3 (
		.clk   (clk),
		.arst_n(arst_n),
		.in_s  (pipe_s2),
		.mul_x (gf_sqr_n(pipe_s2.acc, 4)),
		.mul_y (pipe_s2.acc),
		.out_s (pipe_s3)
	);

	// Stage four: a^1023 = (a^255)^4 * a^3.
	gfau_mul_stage u_stage4 (
		.clk   (clk),
		.arst_n(arst_n),
		.in_s  (pipe_s3),
		.mul_x (gf_sqr_n(pipe_s3.acc, 2)),
		.mul_y (pipe_s3.p3),
		.out_s (pipe_s4)
	);

	// Stage five: a^2047 = (a^1023)^2 * a.
	gfau_mul_stage u_stage5 (
		.clk   (clk),
		.arst_n(arst_n),
		.in_s  (pipe_s4),
		.mul_x (gf_sqr(pipe_s4.acc)),
		.mul_y (pipe_s4.a),
		.out_s (pipe_s5)
	);

	// Output stage: a^4094 = (a^2047)^2, which is zero for a zero input.
	gfau_out u_out (
		.clk   (clk),
		.arst_n(arst_n),
		.in_s  (pipe_s5),
		.done  (done),
		.result(result)
	);

endmodule

[dv/gf4096_arithmetic_unit_core_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gf4096_arithmetic_unit_core_test
// Self-checking bench for the pipelined GF(2^12) multiply, square, invert and
// inequality-mask unit. Directed corner beats come first, then random beats
// under several idling patterns. Every accepted beat is predicted here and
// compared with the result strobed out of the pipeline.
// ----------------------------------------------------------------------------
module gf4096_arithmetic_unit_core_test;
	import gfau_pkg::*;

	// A beat that has been taken by the unit, together with the element that
	// the unit should return for it.
	typedef struct {
		cmd_t  op;
		elem_t a;
		elem_t b;
		elem_t want;
	} field_beat_t;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        start     = 1'b0;
	logic [1:0]  cmd       = CMD_MUL;
	logic [11:0] operand_a = '0;
	logic [11:0] operand_b = '0;
	logic        busy;
	logic        done;
	logic [11:0] result;

	// Beats taken by the unit whose result has not come back yet, oldest first.
	field_beat_t beats_in_flight[$];
	int          error_count   = 0;
	int          beats_sent    = 0;
	int          results_seen  = 0;
	int          op_tally[4]   = '{0, 0, 0, 0};
	int          sender_idle_pct = 0;

	gf4096_arithmetic_unit_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.cmd       (cmd),
		.operand_a (operand_a),
		.operand_b (operand_b),
		.done      (done),
		.result    (result)
	);

	always #5 clk = ~clk;

	// ------------------------------------------------------------------
	// Field arithmetic used for prediction. Elements are polynomials over
	// GF(2) of degree below twelve, reduced by x^12 + x^3 + 1.
	// ------------------------------------------------------------------

	// Schoolbook carry-less product, then the top eleven bits are folded
	// away one at a time from the highest down, using x^12 = x^3 + 1.
	function automatic elem_t field_product(elem_t x, elem_t y);
		logic [22:0] wide;
		wide = '0;
		for (int i = 0; i < 12; i++) begin
			if (y[i]) begin
				wide = wide ^ (23'(x) << i);
			end
		end
		for (int i = 22; i >= 12; i--) begin
			if (wide[i]) begin
				wide[i]      = 1'b0;
				wide[i - 9]  = ~wide[i - 9];
				wide[i - 12] = ~wide[i - 12];
			end
		end
		return wide[11:0];
	endfunction

	function automatic elem_t field_square(elem_t x);
		return field_product(x, x);
	endfunction

	// Raises x to 4094 = 2^12 - 2 along the same fixed addition chain that
	// the hardware is specified with, so that zero maps onto zero.
	function automatic elem_t field_inverse(elem_t x);
		elem_t cube, pow15, acc;
		cube  = field_product(field_square(x), x);
		acc   = field_square(field_square(cube));
		pow15 = field_product(acc, cube);
		acc   = pow15;
		for (int i = 0; i < 4; i++) begin
			acc = field_square(acc);
		end
		acc = field_product(acc, pow15);
		acc = field_square(field_square(acc));
		acc = field_product(acc, cube);
		acc = field_square(acc);
		acc = field_product(acc, x);
		return field_square(acc);
	endfunction

	function automatic elem_t field_op_result(cmd_t op, elem_t a, elem_t b);
		case (op)
			CMD_MUL: return field_product(a, b);
			CMD_SQR: return field_square(a);
			CMD_INV: return field_inverse(a);
			default: return (a != b) ? 12'hFFF : 12'h000;
		endcase
	endfunction

	// ------------------------------------------------------------------
	// Result checker. Outputs are sampled at the rising edge, before any
	// update made at that edge, so a beat is seen exactly as the unit held
	// it during the cycle the edge closes. The result is checked before the
	// new command is logged, since every beat passes through registers before
	// it comes back out.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		field_beat_t oldest;
		if (arst_n) begin
			if (done) begin
				results_seen++;
				if (beats_in_flight.size() == 0) begin
					$display("%0t ns: result %03h arrived with no beat outstanding",
						$time, result);
					error_count++;
				end else begin
					oldest = beats_in_flight.pop_front();
					if (result !== oldest.want) begin
						$display("%0t ns: %s a=%03h b=%03h expected %03h, got %03h",
							$time, oldest.op.name(), oldest.a, oldest.b,
							oldest.want, result);
						error_count++;
					end
				end
			end
			if (start && !busy) begin
				beats_in_flight.push_back('{cmd_t'(cmd), operand_a, operand_b,
					field_op_result(cmd_t'(cmd), operand_a, operand_b)});
				op_tally[cmd]++;
			end
		end
	end

	// ------------------------------------------------------------------
	// Sender. Called just after a rising edge; it presents the command and
	// holds it until the unit takes it. Afterwards the line goes idle one
	// cycle at a time, each cycle drawn with the idling rate of the current
	// phase, so that this share of cycles carries no command. When no idle
	// cycle is drawn start simply stays high for the next beat. While idle
	// the operand lines carry junk, which the unit must ignore.
	// ------------------------------------------------------------------
	task automatic send_beat(input cmd_t op, input elem_t a, input elem_t b);
		start     <= 1'b1;
		cmd       <= op;
		operand_a <= a;
		operand_b <= b;
		do begin
			@(posedge clk);
		end while (!(start && !busy));
		beats_sent++;
		while ($urandom_range(1, 100) <= sender_idle_pct) begin
			start     <= 1'b0;
			cmd       <= cmd_t'($urandom_range(0, 3));
			operand_a <= 12'($urandom);
			operand_b <= 12'($urandom);
			@(posedge clk);
		end
	endtask

	// Drops start and waits until every beat sent so far has come back.
	task automatic wait_for_drain();
		start <= 1'b0;
		while (results_seen < beats_sent) @(posedge clk);
	endtask

	// Operands leaning towards the awkward values: zero, all ones and
	// single set bits, with uniform values for the most part.
	function automatic elem_t pick_operand();
		case ($urandom_range(0, 9))
			0:       return 12'h000;
			1:       return 12'hFFF;
			2:       return 12'h001 << $urandom_range(0, 11);
			default: return 12'($urandom);
		endcase
	endfunction

	// ------------------------------------------------------------------
	// Directed tests
	// ------------------------------------------------------------------

	// Zero on either side, one, all-ones operands, and the top bit
	// squared against itself, which drives the product up to x^22 and makes
	// both folds of the reduction matter.
	task automatic test_multiply_corners();
		send_beat(CMD_MUL, 12'h000, 12'hFFF);
		send_beat(CMD_MUL, 12'hFFF, 12'h000);
		send_beat(CMD_MUL, 12'h001, 12'hA5C);
		send_beat(CMD_MUL, 12'hFFF, 12'hFFF);
		send_beat(CMD_MUL, 12'h800, 12'h800);
		send_beat(CMD_MUL, 12'h555, 12'hAAA);
	endtask

	// Squares ignore operand_b, so it is set to unlike values each time.
	task automatic test_square_corners();
		send_beat(CMD_SQR, 12'h000, 12'hFFF);
		send_beat(CMD_SQR, 12'h001, 12'h000);
		send_beat(CMD_SQR, 12'hFFF, 12'h5A5);
		send_beat(CMD_SQR, 12'h800, 12'hFFF);
	endtask

	// Zero has no inverse; the power chain must hand back zero for it.
	task automatic test_invert_corners();
		send_beat(CMD_INV, 12'h000, 12'hFFF);
		send_beat(CMD_INV, 12'h001, 12'h123);
		send_beat(CMD_INV, 12'h002, 12'h000);
		send_beat(CMD_INV, 12'hFFF, 12'hFFF);
		send_beat(CMD_INV, 12'h800, 12'hABC);
	endtask

	// Equal operands give an all-zero mask, any difference all ones,
	// including a difference in one bit only.
	task automatic test_mask_corners();
		send_beat(CMD_NEQ, 12'h000, 12'h000);
		send_beat(CMD_NEQ, 12'hFFF, 12'hFFF);
		send_beat(CMD_NEQ, 12'h000, 12'hFFF);
		send_beat(CMD_NEQ, 12'h001, 12'h000);
		send_beat(CMD_NEQ, 12'h7FF, 12'hFFF);
	endtask

	// ------------------------------------------------------------------
	// Random traffic. Commands are drawn evenly; for the mask half of the
	// beats reuse operand_a as operand_b, as equal operands would hardly
	// ever turn up by chance.
	// ------------------------------------------------------------------
	task automatic test_random_beats(input int count, input int idle_pct);
		cmd_t  op;
		elem_t a, b;
		sender_idle_pct = idle_pct;
		for (int n = 0; n < count; n++) begin
			op = cmd_t'($urandom_range(0, 3));
			a  = pick_operand();
			b  = pick_operand();
			if (op == CMD_NEQ && $urandom_range(0, 1) == 1) begin
				b = a;
			end
			send_beat(op, a, b);
		end
	endtask

	// Lets the pipe empty out completely in mid-run, then refills it with
	// back-to-back beats, so that the first beat after an idle spell is
	// checked on its own.
	task automatic test_pause_until_drained();
		sender_idle_pct = 0;
		for (int n = 0; n < 6; n++) begin
			send_beat(cmd_t'($urandom_range(0, 3)), pick_operand(), pick_operand());
		end
		wait_for_drain();
		repeat (3) @(posedge clk);
		for (int n = 0; n < 6; n++) begin
			send_beat(cmd_t'($urandom_range(0, 3)), pick_operand(), pick_operand());
		end
	endtask

	// ------------------------------------------------------------------
	// Sequence. The receiver cannot hold results off, so the only idling
	// applied is on the command side: none, 47 in a hundred, none again,
	// then 31 in a hundred.
	// ------------------------------------------------------------------
	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_multiply_corners();
		test_square_corners();
		test_invert_corners();
		test_mask_corners();

		test_random_beats(160, 0);
		test_random_beats(160, 47);
		test_pause_until_drained();
		test_random_beats(160, 0);
		test_random_beats(160, 31);

		wait_for_drain();
		// Wait on after the drain, so that any stray strobe is caught.
		repeat (20) @(posedge clk);

		$display("Checked %0d beats: %0d multiply, %0d square, %0d invert, %0d mask,",
			beats_sent, op_tally[CMD_MUL], op_tally[CMD_SQR], op_tally[CMD_INV],
			op_tally[CMD_NEQ]);
		$display("with corner operands, a full drain mid-run and idling from 0 to 47%%.");
		if (error_count == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

	// Watchdog: ends the run as a failure if it does not finish in time.
	initial begin
		#2_000_000;
		$display("tb: failure");
		$finish;
	end

endmodule

[files.f]
rtl/gfau_pkg.sv
rtl/gfau_front.sv
rtl/gfau_mul_stage.sv
rtl/gfau_out.sv
rtl/gf4096_arithmetic_unit_core.sv
dv/gf4096_arithmetic_unit_core_test.sv
